// File: hw/rtl/deq_pkg.sv
// Shared types and constants of the double-ended queue core.
package deq_pkg;

    // Operation codes carried in the func field of an input word.
    localparam logic [2:0] FUNC_PUSH_BACK  = 3'd0;
    localparam logic [2:0] FUNC_PUSH_FRONT = 3'd1;
    localparam logic [2:0] FUNC_POP_BACK   = 3'd2;
    localparam logic [2:0] FUNC_POP_FRONT  = 3'd3;
    localparam logic [2:0] FUNC_DUMP       = 3'd4;

    // Status codes reported with each result word.
    localparam logic [1:0] STATUS_DONE  = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    // Stream payload widths.
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 40;
    localparam int M_TUSER_W = 3;

    // Command broadcast from the controller to every cell of the chain.
    typedef struct packed {
        logic push_front;  // shift toward the back, new word enters cell 0
        logic push_back;   // first empty cell takes the new word
        logic pop_front;   // shift toward the front
        logic pop_back;    // clear the last occupied cell, load the return path
        logic rotate;      // move the front word to the back, others step forward
        logic ret_shift;   // return path steps one cell toward cell 0
    } cell_cmd_t;

endpackage

// File: hw/rtl/deq_cell.sv
// One storage cell of the deque chain, holding one word and its occupied flag.
module deq_cell #(
    parameter int WORD_WIDTH = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  deq_pkg::cell_cmd_t    cmd,
    input  logic [WORD_WIDTH-1:0] bcast_word,
    input  logic [WORD_WIDTH-1:0] left_word,
    input  logic                  left_occ,
    input  logic [WORD_WIDTH-1:0] right_word,
    input  logic                  right_occ,
    input  logic [WORD_WIDTH-1:0] right_ret,
    output logic [WORD_WIDTH-1:0] word,
    output logic                  occ,
    output logic [WORD_WIDTH-1:0] ret
);
    import deq_pkg::*;

    logic [WORD_WIDTH-1:0] word_reg;
    logic [WORD_WIDTH-1:0] word_next;
    logic                  occ_reg;
    logic                  occ_next;
    logic [WORD_WIDTH-1:0] ret_reg;
    logic [WORD_WIDTH-1:0] ret_next;
    logic                  is_last;

    // This cell holds the back element when it is occupied and its right neighbor is not.
    assign is_last = occ_reg & ~right_occ;

    // Next word and occupied flag from the broadcast command and the neighbors.
    always_comb
    begin
        word_next = word_reg;
        occ_next  = occ_reg;
        if (cmd.push_front)
        begin
            word_next = left_word;
            occ_next  = left_occ;
        end
        else if (cmd.push_back)
        begin
            if (!occ_reg && left_occ)
            begin
                word_next = bcast_word;
                occ_next  = 1'b1;
            end
        end
        else if (cmd.pop_front)
        begin
            word_next = right_word;
            occ_next  = right_occ;
        end
        else if (cmd.pop_back)
        begin
            occ_next = occ_reg & right_occ;
        end
        else if (cmd.rotate)
        begin
            word_next = is_last ? bcast_word : right_word;
        end
    end

    // The return path carries the popped back word toward cell 0, one cell a cycle.
    always_comb
    begin
        ret_next = ret_reg;
        if (cmd.pop_back)
        begin
            ret_next = is_last ? word_reg : '0;
        end
        else if (cmd.ret_shift)
        begin
            ret_next = right_ret;
        end
    end

    // Occupied flag is control state and resets; the data registers do not.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 1'b0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
        ret_reg  <= ret_next;
    end

    assign word = word_reg;
    assign occ  = occ_reg;
    assign ret  = ret_reg;

endmodule

// File: hw/rtl/deq_ctrl.sv
// Sequencer of the deque: decodes operations, drives the cell chain and holds the result word.
module deq_ctrl #(
    parameter int DEPTH = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [2:0]         func,
    input  logic [31:0]        head_word,
    input  logic [31:0]        ret_word,
    output deq_pkg::cell_cmd_t cmd,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [31:0]        out_word,
    output logic [1:0]         status,
    output logic [4:0]         occupancy,
    output logic               is_empty,
    output logic               last
);
    import deq_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int XC = (CW > 5) ? CW : 5;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_POPB = 2'd1;
    localparam logic [1:0] ST_DUMP = 2'd2;

    logic [1:0]    state_reg;
    logic [1:0]    state_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;

    logic          m_valid_reg;
    logic [31:0]   out_word_reg;
    logic [1:0]    status_reg;
    logic [4:0]    occ_out_reg;
    logic          empty_reg;
    logic          last_reg;

    logic          emit_ok;
    logic          accept;
    logic          full;
    logic          empty;
    logic          emit;
    logic [31:0]   e_word;
    logic [1:0]    e_status;
    logic [CW-1:0] e_count;
    logic          e_last;
    logic [XC-1:0] e_count_ext;

    // The result register can take a new word when it is empty or being drained.
    assign emit_ok  = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && emit_ok;
    assign accept   = s_tvalid && s_tready;
    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);

    // Operation decode and sequencing of pop back and dump.
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        count_next = count_reg;
        cnt_next   = cnt_reg;
        emit       = 1'b0;
        e_word     = '0;
        e_status   = STATUS_DONE;
        e_count    = count_reg;
        e_last     = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (func)
                        FUNC_PUSH_BACK, FUNC_PUSH_FRONT:
                        begin
                            emit = 1'b1;
                            if (full)
                            begin
                                e_status = STATUS_FULL;
                            end
                            else
                            begin
                                cmd.push_back  = (func == FUNC_PUSH_BACK);
                                cmd.push_front = (func == FUNC_PUSH_FRONT);
                                count_next     = count_reg + CW'(1);
                                e_count        = count_reg + CW'(1);
                            end
                        end
                        FUNC_POP_BACK:
                        begin
                            if (empty)
                            begin
                                emit     = 1'b1;
                                e_status = STATUS_EMPTY;
                            end
                            else
                            begin
                                cmd.pop_back = 1'b1;
                                count_next   = count_reg - CW'(1);
                                cnt_next     = count_reg - CW'(1);
                                state_next   = ST_POPB;
                            end
                        end
                        FUNC_POP_FRONT:
                        begin
                            emit = 1'b1;
                            if (empty)
                            begin
                                e_status = STATUS_EMPTY;
                            end
                            else
                            begin
                                cmd.pop_front = 1'b1;
                                count_next    = count_reg - CW'(1);
                                e_count       = count_reg - CW'(1);
                                e_word        = head_word;
                            end
                        end
                        FUNC_DUMP:
                        begin
                            if (empty)
                            begin
                                emit     = 1'b1;
                                e_status = STATUS_EMPTY;
                            end
                            else
                            begin
                                cnt_next   = count_reg;
                                state_next = ST_DUMP;
                            end
                        end
                        default:
                        begin
                            emit = 1'b1;
                        end
                    endcase
                end
            end
            ST_POPB:
            begin
                // Wait until the back word has travelled down to cell 0.
                if (cnt_reg == '0)
                begin
                    if (emit_ok)
                    begin
                        emit       = 1'b1;
                        e_word     = ret_word;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    cmd.ret_shift = 1'b1;
                    cnt_next      = cnt_reg - CW'(1);
                end
            end
            ST_DUMP:
            begin
                // Emit the front word and rotate it to the back, once per element.
                if (emit_ok)
                begin
                    emit       = 1'b1;
                    e_word     = head_word;
                    e_last     = (cnt_reg == CW'(1));
                    cmd.rotate = 1'b1;
                    cnt_next   = cnt_reg - CW'(1);
                    if (cnt_reg == CW'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign e_count_ext = XC'(e_count);

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            cnt_reg   <= cnt_next;
            if (emit)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Result word register.
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_word_reg <= e_word;
            status_reg   <= e_status;
            occ_out_reg  <= e_count_ext[4:0];
            empty_reg    <= (e_count == '0);
            last_reg     <= e_last;
        end
    end

    assign m_tvalid  = m_valid_reg;
    assign out_word  = out_word_reg;
    assign status    = status_reg;
    assign occupancy = occ_out_reg;
    assign is_empty  = empty_reg;
    assign last      = last_reg;

    // The element count never exceeds the number of cells.
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= CW'(DEPTH))
        else $error("deque element count beyond depth");

    // A dump in progress always has elements left to emit.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DUMP) |-> (cnt_reg != '0))
        else $error("dump running with no elements left");

    // The popped back word starts at the new count and only moves toward cell 0.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_POPB) |-> (cnt_reg <= count_reg))
        else $error("pop back distance beyond element count");

    // The final dump word returns the sequencer to idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DUMP && emit_ok && cnt_reg == CW'(1)) |=> (state_reg == ST_IDLE))
        else $error("dump did not finish after its last word");

endmodule

// File: hw/rtl/double_ended_queue_core.sv
// Top level of the double-ended queue core: a chain of storage cells and its sequencer.
//
// A double-ended queue of up to DEPTH words of WORD_WIDTH bits, kept in a row of cells
// with the front element always in cell 0. Each input word is one operation (push back,
// push front, pop back, pop front, dump) and gives one result word, except a dump of a
// non-empty deque, which gives one result per element from front to back with tlast on
// the back element. Pushes, pop front, and operations on a full or empty deque complete in the
// idle state. Pop back waits while the back word travels down the return path of the cell
// chain one cell per cycle, and a dump rotates the chain once per emitted element.
// No clearing pass follows reset; the deque is empty as soon as reset is released.
module double_ended_queue_core #(
    parameter int DEPTH      = 16,
    parameter int WORD_WIDTH = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // s_tdata fields from bit 0: func[2:0], push_word[31:0], zero fill.
    input  logic [deq_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // m_tdata fields from bit 0: out_word[31:0], occupancy[4:0], zero fill.
    output logic [deq_pkg::M_TDATA_W-1:0]   m_tdata,
    // m_tuser fields from bit 0: status[1:0], is_empty.
    output logic [deq_pkg::M_TUSER_W-1:0]   m_tuser,
    output logic                            m_tlast
);
    import deq_pkg::*;

    localparam int XW = (WORD_WIDTH > 32) ? WORD_WIDTH : 32;

    cell_cmd_t             cmd;
    logic [XW-1:0]         push_ext;
    logic [WORD_WIDTH-1:0] push_w;
    logic [WORD_WIDTH-1:0] bcast_word;
    logic [XW-1:0]         head_ext;
    logic [XW-1:0]         ret_ext;
    logic [31:0]           out_word;
    logic [1:0]            status;
    logic [4:0]            occupancy;
    logic                  is_empty;

    logic [WORD_WIDTH-1:0] cell_word [DEPTH];
    logic                  cell_occ  [DEPTH];
    logic [WORD_WIDTH-1:0] cell_ret  [DEPTH];

    // The pushed word is cut to the stored width; rotation feeds the front word back in.
    assign push_ext   = XW'(s_tdata[34:3]);
    assign push_w     = push_ext[WORD_WIDTH-1:0];
    assign bcast_word = cmd.rotate ? cell_word[0] : push_w;

    // Words leaving cell 0 are sized to the 32-bit result field.
    assign head_ext = XW'(cell_word[0]);
    assign ret_ext  = XW'(cell_ret[0]);

    // Chain of cells, each wired to its two neighbors.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [WORD_WIDTH-1:0] left_word;
        logic                  left_occ;
        logic [WORD_WIDTH-1:0] right_word;
        logic                  right_occ;
        logic [WORD_WIDTH-1:0] right_ret;

        if (i == 0)
        begin : g_head
            assign left_word = bcast_word;
            assign left_occ  = 1'b1;
        end
        else
        begin : g_mid
            assign left_word = cell_word[i-1];
            assign left_occ  = cell_occ[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign right_word = '0;
            assign right_occ  = 1'b0;
            assign right_ret  = '0;
        end
        else
        begin : g_body
            assign right_word = cell_word[i+1];
            assign right_occ  = cell_occ[i+1];
            assign right_ret  = cell_ret[i+1];
        end

        deq_cell #(
            .WORD_WIDTH (WORD_WIDTH)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cmd        (cmd),
            .bcast_word (bcast_word),
            .left_word  (left_word),
            .left_occ   (left_occ),
            .right_word (right_word),
            .right_occ  (right_occ),
            .right_ret  (right_ret),
            .word       (cell_word[i]),
            .occ        (cell_occ[i]),
            .ret        (cell_ret[i])
        );
    end

    // Sequencer and result register.
    deq_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .func      (s_tdata[2:0]),
        .head_word (head_ext[31:0]),
        .ret_word  (ret_ext[31:0]),
        .cmd       (cmd),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .out_word  (out_word),
        .status    (status),
        .occupancy (occupancy),
        .is_empty  (is_empty),
        .last      (m_tlast)
    );

    // Result payload packing.
    assign m_tdata = {3'b000, occupancy, out_word};
    assign m_tuser = {is_empty, status};

endmodule

// File: tb/sv/tb.sv
// Self-checking stream testbench for the double-ended queue core.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import deq_pkg::*;

    localparam int DEPTH = 16;
    localparam int WORD_WIDTH = 32;
    localparam int RANDOM_OPS = 85;
    localparam int HOLD_AT_WORD = 30;
    localparam int HOLD_CYCLES = 120;
    localparam int DRAIN_AT_OP = 70;
    localparam int SETTLE_CYCLES = 40;
    localparam logic [2:0] FUNC_UNUSED_LO = 3'd5;

    typedef enum int { MODE_FILL, MODE_DRAIN, MODE_MIX } gen_mode_t;

    // One operation waiting to be offered, optionally only once all results are back.
    typedef struct {
        logic [2:0]  func;
        logic [31:0] push_word;
        bit          drain_first;
    } pending_op_t;

    // Fields of one expected result word.
    typedef struct {
        logic [31:0] out_word;
        logic [1:0]  status;
        logic [4:0]  occupancy;
        logic        is_empty;
        logic        last;
    } deque_result_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [S_TDATA_W-1:0]    s_tdata = '0;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [M_TDATA_W-1:0]    m_tdata;
    logic [M_TUSER_W-1:0]    m_tuser;
    logic                    m_tlast;

    // Shadow copy of the deque contents.
    logic [WORD_WIDTH-1:0]   store_slots [DEPTH];
    logic [3:0]              head_slot = '0;
    logic [4:0]              live_count = '0;

    pending_op_t             ops_to_send [$];
    deque_result_t           results_due [$];
    int                      total_ops = 0;
    int                      words_offered = 0;
    int                      fail_cnt = 0;
    int                      shadow_count = 0;

    double_ended_queue_core #(
        .DEPTH      (DEPTH),
        .WORD_WIDTH (WORD_WIDTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Clock, 4 ns period.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Record one expected result with the occupancy after the operation.
    function automatic void push_result(logic [31:0] word, logic [1:0] status, logic fin);
        deque_result_t r;
        r.out_word  = word;
        r.status    = status;
        r.occupancy = live_count;
        r.is_empty  = (live_count == 0);
        r.last      = fin;
        results_due.push_back(r);
    endfunction

    // Apply one operation to the shadow deque and queue the results it causes.
    function automatic void apply_deque_op(logic [2:0] func, logic [31:0] word);
        logic [3:0]  slot;
        logic [31:0] taken;
        case (func)
            FUNC_PUSH_BACK, FUNC_PUSH_FRONT:
            begin
                if (live_count >= DEPTH)
                    push_result('0, STATUS_FULL, 1'b1);
                else
                begin
                    if (func == FUNC_PUSH_BACK)
                    begin
                        slot = head_slot + live_count[3:0];
                        store_slots[slot] = word;
                    end
                    else
                    begin
                        head_slot = head_slot - 4'd1;
                        store_slots[head_slot] = word;
                    end
                    live_count = live_count + 5'd1;
                    push_result('0, STATUS_DONE, 1'b1);
                end
            end
            FUNC_POP_BACK, FUNC_POP_FRONT:
            begin
                if (live_count == 0)
                    push_result('0, STATUS_EMPTY, 1'b1);
                else
                begin
                    if (func == FUNC_POP_BACK)
                    begin
                        slot = head_slot + 4'(live_count - 5'd1);
                        taken = store_slots[slot];
                    end
                    else
                    begin
                        taken = store_slots[head_slot];
                        head_slot = head_slot + 4'd1;
                    end
                    live_count = live_count - 5'd1;
                    push_result(taken, STATUS_DONE, 1'b1);
                end
            end
            FUNC_DUMP:
            begin
                if (live_count == 0)
                    push_result('0, STATUS_EMPTY, 1'b1);
                else
                    for (int i = 0; i < live_count; i++)
                    begin
                        slot = head_slot + 4'(i);
                        push_result(store_slots[slot], STATUS_DONE, i == live_count - 1);
                    end
            end
            default:
                push_result('0, STATUS_DONE, 1'b1);
        endcase
    endfunction

    // Queue one operation for the driver, tracking the occupancy it leaves behind.
    function automatic void add_op(logic [2:0] func, logic [31:0] word, bit drain_first);
        pending_op_t op;
        op.func = func;
        op.push_word = word;
        op.drain_first = drain_first;
        ops_to_send.push_back(op);
        if ((func == FUNC_PUSH_BACK || func == FUNC_PUSH_FRONT) && shadow_count < DEPTH)
            shadow_count++;
        else if ((func == FUNC_POP_BACK || func == FUNC_POP_FRONT) && shadow_count > 0)
            shadow_count--;
    endfunction

    // Idle percentage for the current third of the run.
    function automatic int idle_pct(bit sender);
        if (words_offered < total_ops / 3)
            return sender ? 14 : 52;
        else if (words_offered < 2 * total_ops / 3)
            return sender ? 52 : 14;
        return 0;
    endfunction

    function automatic void check_field(string name, longint unsigned want, longint unsigned got);
        if (want != got)
        begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            fail_cnt++;
        end
    endfunction

    // Input driver: presents the next word, with random idle gaps, whenever the bus slot is free.
    // A word that waits for the drain also waits until the previous word has left the bus.
    always @(posedge clk or negedge rst_n)
    begin : input_driver
        pending_op_t op;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (ops_to_send.size() > 0
                && !(ops_to_send[0].drain_first && (results_due.size() > 0 || s_tvalid))
                && $urandom_range(99) >= idle_pct(1'b1))
            begin
                op = ops_to_send.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= {{(S_TDATA_W - 35){1'b0}}, op.push_word, op.func};
                words_offered++;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Output ready: random stalls, plus one long hold-off to back the core up.
    always @(posedge clk or negedge rst_n)
    begin : output_ready
        int hold_left;
        bit hold_done;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            hold_left = 0;
            hold_done = 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else if (!hold_done && words_offered >= HOLD_AT_WORD)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= idle_pct(1'b0));
    end

    // Monitor: predict on each accepted input word, check each accepted result word.
    always @(posedge clk)
    begin : monitor
        deque_result_t want;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                apply_deque_op(s_tdata[2:0], s_tdata[34:3]);
            if (m_tvalid && m_tready)
            begin
                if (results_due.size() == 0)
                begin
                    $error("unexpected result word: tdata 0x%0h tuser 0x%0h", m_tdata, m_tuser);
                    fail_cnt++;
                end
                else
                begin
                    want = results_due.pop_front();
                    check_field("out_word", want.out_word, m_tdata[31:0]);
                    check_field("occupancy", want.occupancy, m_tdata[36:32]);
                    check_field("status", want.status, m_tuser[1:0]);
                    check_field("is_empty", want.is_empty, m_tuser[2]);
                    check_field("last", want.last, m_tlast);
                end
            end
        end
    end

    // Watchdog.
    initial
    begin
        #2_000_000;
        $display("FAIL double_ended_queue_core");
        $finish;
    end

    // Stimulus, reset and end of run.
    initial
    begin : main_sequence
        gen_mode_t   mode;
        int          real_ops;
        int          roll;
        bit          dumped_full;
        logic [2:0]  func;
        logic [31:0] word;

        // Directed: empty cases, word extremes, every operation, unused codes, front wrap.
        add_op(FUNC_DUMP, '0, 1'b0);
        add_op(FUNC_POP_BACK, 32'hFFFF_FFFF, 1'b0);
        add_op(FUNC_POP_FRONT, '0, 1'b0);
        add_op(FUNC_PUSH_BACK, 32'h0000_0000, 1'b0);
        add_op(FUNC_PUSH_BACK, 32'hFFFF_FFFF, 1'b0);
        add_op(FUNC_PUSH_FRONT, 32'hA5A5_5A5A, 1'b0);
        add_op(FUNC_PUSH_FRONT, 32'h0000_0001, 1'b0);
        add_op(FUNC_DUMP, 32'hFFFF_FFFF, 1'b0);
        add_op(FUNC_POP_BACK, '0, 1'b0);
        add_op(FUNC_POP_FRONT, '0, 1'b0);
        add_op(FUNC_UNUSED_LO, 32'hFFFF_FFFF, 1'b0);
        add_op(FUNC_UNUSED_LO + 3'd1, 32'h5555_5555, 1'b0);
        add_op(FUNC_UNUSED_LO + 3'd2, 32'hAAAA_AAAA, 1'b0);
        add_op(FUNC_POP_FRONT, '0, 1'b0);
        add_op(FUNC_POP_BACK, '0, 1'b0);
        add_op(FUNC_PUSH_FRONT, 32'h1234_5678, 1'b0);
        add_op(FUNC_PUSH_BACK, 32'h8000_0000, 1'b0);
        add_op(FUNC_DUMP, '0, 1'b0);
        add_op(FUNC_POP_BACK, '0, 1'b0);
        add_op(FUNC_POP_FRONT, '0, 1'b0);

        // Random: fill and drain sweeps so that full and empty are both reached often.
        mode = MODE_FILL;
        real_ops = 0;
        dumped_full = 1'b0;
        while (real_ops < RANDOM_OPS)
        begin
            roll = $urandom_range(99);
            word = ($urandom_range(9) == 0) ? ($urandom_range(1) ? 32'hFFFF_FFFF : 32'h0)
                                            : $urandom();
            if (!dumped_full && shadow_count == DEPTH)
            begin
                func = FUNC_DUMP;
                dumped_full = 1'b1;
            end
            else if (roll < 4)
                func = FUNC_UNUSED_LO + 3'($urandom_range(2));
            else if (roll < 14)
                func = FUNC_DUMP;
            else if ($urandom_range(99) < (mode == MODE_FILL ? 85 : mode == MODE_DRAIN ? 15 : 50))
                func = $urandom_range(1) ? FUNC_PUSH_BACK : FUNC_PUSH_FRONT;
            else
                func = $urandom_range(1) ? FUNC_POP_BACK : FUNC_POP_FRONT;

            if (func < FUNC_UNUSED_LO)
            begin
                add_op(func, word, real_ops == DRAIN_AT_OP);
                real_ops++;
            end
            else
                add_op(func, word, 1'b0);

            if (mode == MODE_FILL && shadow_count == DEPTH && $urandom_range(99) < 25)
                mode = MODE_DRAIN;
            else if (mode == MODE_DRAIN && shadow_count == 0 && $urandom_range(99) < 30)
                mode = $urandom_range(1) ? MODE_FILL : MODE_MIX;
            else if (mode == MODE_MIX && $urandom_range(99) < 8)
                mode = MODE_FILL;
        end
        total_ops = ops_to_send.size();

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for every word to be taken, then for every result to come back.
        while (ops_to_send.size() > 0 || s_tvalid)
            @(posedge clk);
        while (results_due.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (fail_cnt == 0)
            $display("PASS double_ended_queue_core");
        else
            $display("FAIL double_ended_queue_core");
        $finish;
    end

endmodule
